// File: rtl/assert_macros.svh
// Assertion helper macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/wrsi_pkg.sv
// ---------------------------------------------------------------------------
// wrsi_pkg
// Shared types and constants of the Wilder RSI stream block.
// ---------------------------------------------------------------------------
package wrsi_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int AVG_W           = 48;
    localparam int CNT_W           = 17;
    localparam int PER_W           = 16;
    localparam int RSI_W           = 23;
    localparam int DIV_W           = 64;
    localparam logic [PER_W-1:0] PERIOD_RESET = 16'd14;
    localparam logic [7:0] HUNDRED = 8'd100;

    typedef enum logic [1:0] {
        SEL_GAIN  = 2'd0,
        SEL_LOSS  = 2'd1,
        SEL_RATIO = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     prep;
        logic     div_start;
        div_sel_t div_sel;
        logic     latch;
        logic     commit;
    } wrsi_cmd_t;

    typedef struct packed {
        logic div_done;
        logic phase_smooth;
        logic phase_first;
        logic total_zero;
    } wrsi_stat_t;

endpackage

// File: rtl/wrsi_div.sv
// ---------------------------------------------------------------------------
// wrsi_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ---------------------------------------------------------------------------
module wrsi_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wrsi_pkg::DIV_W-1:0]   dividend,
    input  logic [wrsi_pkg::DIV_W-1:0]   divisor,
    output logic                         done,
    output logic [wrsi_pkg::DIV_W-1:0]   quotient
);
    localparam int W = wrsi_pkg::DIV_W;

    logic [W-1:0]         q_reg, q_next;
    logic [W:0]           r_reg, r_next;
    logic [W-1:0]         d_reg, d_next;
    logic [$clog2(W):0]   cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [W:0]           trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[W-1:0], q_reg[W-1]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(W)+1)'(W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/wrsi_datapath.sv
// ---------------------------------------------------------------------------
// wrsi_datapath
// State registers, smoothing operands and the shared divider.
// ---------------------------------------------------------------------------
module wrsi_datapath
#(
    parameter int VALUE_WIDTH = wrsi_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = wrsi_pkg::FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  wrsi_pkg::wrsi_cmd_t            cmd,
    output wrsi_pkg::wrsi_stat_t           stat,
    input  logic                           in_peek,
    input  logic [31:0]                    in_sample,
    input  logic [wrsi_pkg::PER_W-1:0]     period,
    output logic [wrsi_pkg::RSI_W-1:0]     res_rsi,
    output logic                           res_valid
);
    localparam int AW = wrsi_pkg::AVG_W;
    localparam int DW = wrsi_pkg::DIV_W;
    localparam int CW = wrsi_pkg::CNT_W;
    localparam int RSI_W_L = wrsi_pkg::RSI_W;
    localparam logic [AW-1:0] AVG_MAX = {AW{1'b1}};

    logic signed [VALUE_WIDTH-1:0] last_reg, x_reg;
    logic [AW-1:0]  gain_reg, loss_reg;
    logic [CW-1:0]  cnt_reg;
    logic [AW-1:0]  g_reg, l_reg;
    logic [DW-1:0]  gnum_reg, lnum_reg;
    logic [CW-1:0]  p_reg;
    logic           peek_reg, smooth_reg, first_reg;
    logic [RSI_W_L-1:0] rsi_reg;
    logic           valid_reg;

    logic signed [VALUE_WIDTH-1:0] x_in;
    logic signed [VALUE_WIDTH:0]   delta;
    logic [VALUE_WIDTH:0]          rise, fall;
    logic [CW-1:0]                 p_eff;
    logic [AW:0]                   gs, ls;
    logic [DW-1:0]                 div_a, div_b, quot;
    logic                          div_done;
    logic [AW:0]                   total;

    assign x_in  = in_sample[VALUE_WIDTH-1:0];
    assign delta = {x_in[VALUE_WIDTH-1], x_in} - {last_reg[VALUE_WIDTH-1], last_reg};
    assign rise  = (!delta[VALUE_WIDTH] && delta != '0) ? delta : '0;
    assign fall  = (!delta[VALUE_WIDTH] && delta != '0) ? '0 : (VALUE_WIDTH+1)'(-delta);
    assign p_eff = (period < 16'd2) ? CW'(2) : CW'(period);
    assign gs    = {1'b0, gain_reg} + (AW+1)'(rise);
    assign ls    = {1'b0, loss_reg} + (AW+1)'(fall);
    assign total = {1'b0, g_reg} + {1'b0, l_reg};

    always_comb
    begin
        div_a = gnum_reg;
        div_b = DW'(p_reg);
        case (cmd.div_sel)
            wrsi_pkg::SEL_GAIN:  div_a = gnum_reg;
            wrsi_pkg::SEL_LOSS:  div_a = lnum_reg;
            default:
            begin
                div_a = DW'(g_reg) * DW'(wrsi_pkg::HUNDRED) << FRAC_BITS;
                div_b = DW'(total);
            end
        endcase
    end

    wrsi_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            x_reg      <= x_in;
            peek_reg   <= in_peek;
            p_reg      <= p_eff;
            smooth_reg <= cnt_reg > p_eff;
            first_reg  <= cnt_reg == p_eff;
            if (cnt_reg > p_eff)
            begin
                gnum_reg <= DW'(gain_reg) * DW'(p_eff - 1'b1) + DW'(rise);
                lnum_reg <= DW'(loss_reg) * DW'(p_eff - 1'b1) + DW'(fall);
            end
            else
            begin
                if (cnt_reg != '0)
                begin
                    g_reg <= gs[AW] ? AVG_MAX : gs[AW-1:0];
                    l_reg <= ls[AW] ? AVG_MAX : ls[AW-1:0];
                    gnum_reg <= DW'(gs[AW] ? AVG_MAX : gs[AW-1:0]);
                    lnum_reg <= DW'(ls[AW] ? AVG_MAX : ls[AW-1:0]);
                end
                else
                begin
                    g_reg <= gain_reg;
                    l_reg <= loss_reg;
                    gnum_reg <= DW'(gain_reg);
                    lnum_reg <= DW'(loss_reg);
                end
            end
        end
        if (cmd.latch)
        begin
            case (cmd.div_sel)
                wrsi_pkg::SEL_GAIN:  g_reg <= quot[AW-1:0];
                wrsi_pkg::SEL_LOSS:  l_reg <= quot[AW-1:0];
                default:             rsi_reg <= quot[RSI_W_L-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            gain_reg  <= '0;
            loss_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            valid_reg <= smooth_reg || first_reg;
            if (!peek_reg)
            begin
                last_reg <= x_reg;
                gain_reg <= g_reg;
                loss_reg <= l_reg;
                cnt_reg  <= smooth_reg ? p_reg + 1'b1 : cnt_reg + 1'b1;
            end
        end
    end

    assign stat.div_done     = div_done;
    assign stat.phase_smooth = smooth_reg;
    assign stat.phase_first  = first_reg;
    assign stat.total_zero   = total == '0;
    assign res_valid = valid_reg;
    assign res_rsi   = valid_reg ? rsi_reg : '0;

endmodule

// File: rtl/wrsi_ctrl.sv
// ---------------------------------------------------------------------------
// wrsi_ctrl
// Sequencer for one item: prepare, divide gain and loss and form the ratio (skipped in lookback), then deliver.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module wrsi_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  out_fire,
    output logic                  in_ready,
    output logic                  out_valid,
    output logic                  zero_rsi,
    output wrsi_pkg::wrsi_cmd_t   cmd,
    input  wrsi_pkg::wrsi_stat_t  stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_GW, S_LS, S_LW, S_RS, S_RW, S_COMMIT, S_OUT
    } state_t;

    state_t state_reg;
    logic   zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            zero_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:   if (in_fire) state_reg <= S_PREP;
                S_PREP:
                begin
                    if (stat.phase_smooth || stat.phase_first) state_reg <= S_GW;
                    else state_reg <= S_COMMIT;
                end
                S_GW:     if (stat.div_done) state_reg <= S_LS;
                S_LS:     state_reg <= S_LW;
                S_LW:     if (stat.div_done) state_reg <= S_RS;
                S_RS:
                begin
                    zero_reg  <= stat.total_zero;
                    state_reg <= S_RW;
                end
                S_RW:     if (stat.div_done || zero_reg) state_reg <= S_COMMIT;
                S_COMMIT: state_reg <= S_OUT;
                S_OUT:    if (out_fire) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd = '0;
        cmd.div_sel = wrsi_pkg::SEL_GAIN;
        unique case (state_reg)
            S_IDLE:   cmd.prep = in_fire;
            S_PREP:   cmd.div_start = stat.phase_smooth || stat.phase_first;
            S_GW:     cmd.latch = stat.div_done;
            S_LS:
            begin
                cmd.div_sel   = wrsi_pkg::SEL_LOSS;
                cmd.div_start = 1'b1;
            end
            S_LW:
            begin
                cmd.div_sel = wrsi_pkg::SEL_LOSS;
                cmd.latch   = stat.div_done;
            end
            S_RS:
            begin
                cmd.div_sel   = wrsi_pkg::SEL_RATIO;
                cmd.div_start = !stat.total_zero;
            end
            S_RW:
            begin
                cmd.div_sel = wrsi_pkg::SEL_RATIO;
                cmd.latch   = stat.div_done && !zero_reg;
            end
            S_COMMIT: cmd.commit = 1'b1;
            default:  cmd.prep = 1'b0;
        endcase
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign zero_rsi  = zero_reg;

    `ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `ASSERT_NEXT(a_commit_out, clk, rst_n, cmd.commit, out_valid)
    `ASSERT_IMPL(a_start_busy, clk, rst_n, cmd.div_start, !in_ready && !out_valid)

endmodule

// File: rtl/wilder_rsi_stream.sv
// ---------------------------------------------------------------------------
// wilder_rsi_stream
// Streaming relative strength index with Wilder smoothing.
//
// Channel   Direction  Contents
// s_axis    in         tdata[31:0] sample_value, tuser[0] op
// m_axis    out        tdata[22:0] rsi, tuser[0] valid_res
// apb       in         register 0 period at address 0
//
// One item at a time. Lookback items skip the divider; others pass through the
// shared divider for gain, for loss and, unless both are zero, for the ratio.
// Reset is asynchronous and active low; it clears control, period and committed state, not the working registers.
// A stalled result holds the block until it is taken.
// ---------------------------------------------------------------------------
module wilder_rsi_stream
#(
    parameter int VALUE_WIDTH = wrsi_pkg::VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = wrsi_pkg::FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_value
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // rsi, zero fill
    output logic        m_axis_tuser,   // valid_res
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [wrsi_pkg::PER_W-1:0] period_reg;
    wrsi_pkg::wrsi_cmd_t  cmd;
    wrsi_pkg::wrsi_stat_t stat;
    logic [wrsi_pkg::RSI_W-1:0] rsi;
    logic valid_res, zero_rsi;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, period_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= wrsi_pkg::PERIOD_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0)
            period_reg <= pwdata[15:0];
    end

    wrsi_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid && s_axis_tready),
        .out_fire  (m_axis_tvalid && m_axis_tready),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .zero_rsi  (zero_rsi),
        .cmd       (cmd),
        .stat      (stat)
    );

    wrsi_datapath #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_peek   (s_axis_tuser),
        .in_sample (s_axis_tdata),
        .period    (period_reg),
        .res_rsi   (rsi),
        .res_valid (valid_res)
    );

    assign m_axis_tdata = {1'b0, zero_rsi ? '0 : rsi};
    assign m_axis_tuser = valid_res;

endmodule
